@@ rtl/sbs_pkg.sv @@
package sbs_pkg;

	// Field and register widths
	localparam int PERIOD_W = 26;
	localparam int DIM_W    = 12;
	localparam int HB_W     = 11;
	localparam int VB_W     = 16;
	localparam int FINE_W   = 13;

	// Row length W + blanking, up to 4095 + 2047
	localparam int ROW_W = 13;
	// Row count H + v, bounded by P / (W + 61)
	localparam int ROWS_W = 21;
	// Rounded quotient P / rows with rows of at least four
	localparam int QUO_W = 24;

	// Shared divider operand widths
	localparam int DIVIDEND_W = PERIOD_W + 1;
	localparam int DIVISOR_W  = ROWS_W;

	// Blanking limits and period trim
	localparam int HB_MIN      = 61;
	localparam int HB_MAX      = 1023;
	localparam int VB_MIN      = 4;
	localparam int PERIOD_TRIM = 4;
	localparam int HB_SAT      = 2047;
	localparam int VB_SAT      = 65535;

	// Register reset values
	localparam int RESET_WIDTH  = 752;
	localparam int RESET_HEIGHT = 480;

	localparam int DEF_MAX_SEARCH_STEPS = 1024;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

endpackage

@@ rtl/sbs_div.sv @@
module sbs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sbs_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [sbs_pkg::DIVISOR_W-1:0]  divisor,
	output logic                           done,
	output logic [sbs_pkg::DIVIDEND_W-1:0] quotient,
	output logic [sbs_pkg::DIVISOR_W-1:0]  remainder
);
	import sbs_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;
	logic                  last_bit;

	// Bring down the next dividend bit and try the subtract
	assign trial    = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign fits     = trial >= {1'b0, dvs_q};
	assign last_bit = busy_q && (cnt_q == CNT_W'(DIVIDEND_W - 1));

	// One quotient bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
				rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/sensor_blanking_search_core.sv @@
// Sensor blanking search: picks horizontal and vertical blanking so that
// (W + h) * (H + v) comes closest to a wanted frame period, then splits the
// exposure into whole rows and leftover pixels at the new row length.
// Configuration: cfg_we writes cfg_data into active_width (index 0) or
// active_height (index 1) at once; write only while no transaction is in work.
// Input channel: in_valid/in_ready carry frame_period_pixels and
// exposure_pixels. in_ready is high only while the search engine is idle.
// Output channel: out_valid/out_ready carry one result transaction per input.
// Each search tries N vertical blanking values (at most MAX_SEARCH_STEPS).
// Every division goes through one shared restoring divider that produces one
// quotient bit per cycle. A new input is taken only once the search engine has
// finished the previous search and gone back to idle.
// The output register lets the next input be taken while a result waits; a
// finished search holds until that register frees up.
// Reset: registers return to 752 x 480, the engine goes idle, no result valid.
module sensor_blanking_search_core #(
	parameter int MAX_SEARCH_STEPS = sbs_pkg::DEF_MAX_SEARCH_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbs_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbs_pkg::PERIOD_W-1:0]  frame_period_pixels,
	input  logic [sbs_pkg::PERIOD_W-1:0]  exposure_pixels,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbs_pkg::HB_W-1:0]      hblank,
	output logic [sbs_pkg::VB_W-1:0]      vblank,
	output logic [sbs_pkg::PERIOD_W-1:0]  fit_error,
	output logic [sbs_pkg::PERIOD_W-1:0]  coarse_rows,
	output logic [sbs_pkg::FINE_W-1:0]    fine_pixels,
	output logic                          exposure_too_long,
	output logic                          found
);
	import sbs_pkg::*;

	localparam int STEP_W = $clog2(MAX_SEARCH_STEPS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_LO,
		ST_DIV_HI,
		ST_CHECK,
		ST_DIV_STEP,
		ST_SAT,
		ST_ROW,
		ST_DIV_EXP,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Search context
	logic [PERIOD_W-1:0] p_q;
	logic [PERIOD_W-1:0] expo_q;
	logic                too_long_q;
	logic                found_q;
	logic [PERIOD_W-1:0] best_err_q;
	logic [QUO_W-1:0]    best_quo_q;
	logic [ROWS_W-1:0]   best_rows_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [ROWS_W-1:0]   rhi_q;
	logic [STEP_W-1:0]   steps_q;
	logic [HB_W-1:0]     hb_q;
	logic [VB_W-1:0]     vb_q;
	logic [PERIOD_W-1:0] coarse_q;
	logic [FINE_W-1:0]   fine_q;

	// Divider command
	logic                  div_start_q;
	logic [DIVIDEND_W-1:0] div_dividend_q;
	logic [DIVISOR_W-1:0]  div_divisor_q;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic [DIVISOR_W-1:0]  div_rem;

	// Output register
	logic                out_valid_q;
	logic [HB_W-1:0]     hblank_q;
	logic [VB_W-1:0]     vblank_q;
	logic [PERIOD_W-1:0] fit_error_q;
	logic [PERIOD_W-1:0] coarse_rows_q;
	logic [FINE_W-1:0]   fine_pixels_q;
	logic                too_long_out_q;
	logic                found_out_q;

	// Combinational helpers
	logic [ROW_W-1:0]      row_max;
	logic [ROW_W-1:0]      row_min;
	logic [ROWS_W-1:0]     rows_floor;
	logic [DIVIDEND_W-1:0] ceil_dividend;
	logic [ROWS_W-1:0]     ceil_rows;
	logic                  round_up;
	logic [ROWS_W-1:0]     step_err;
	logic [QUO_W-1:0]      step_quo;
	logic                  step_better;
	logic [QUO_W-1:0]      hb_diff;
	logic [ROWS_W-1:0]     vb_diff;
	logic [ROW_W-1:0]      row_len;
	logic                  accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Row length bounds and the lowest row count allowed
	assign row_max    = ROW_W'(width_q) + ROW_W'(HB_MAX);
	assign row_min    = ROW_W'(width_q) + ROW_W'(HB_MIN);
	assign rows_floor = ROWS_W'(height_q) + ROWS_W'(VB_MIN);

	// Ceiling of P / row_max taken as (period - 4 + row_max - 1) / row_max
	assign ceil_dividend = DIVIDEND_W'(frame_period_pixels) + DIVIDEND_W'(row_max)
		- DIVIDEND_W'(PERIOD_TRIM + 1);
	assign ceil_rows = div_quo[ROWS_W-1:0];

	// Round P / rows half up and take the error to the nearest multiple
	assign round_up    = {div_rem, 1'b0} >= {1'b0, rows_q};
	assign step_err    = round_up ? (rows_q - div_rem) : div_rem;
	assign step_quo    = div_quo[QUO_W-1:0] + QUO_W'(round_up);
	assign step_better = PERIOD_W'(step_err) < best_err_q;

	// Blanking before saturation
	assign hb_diff = best_quo_q - QUO_W'(width_q);
	assign vb_diff = best_rows_q - ROWS_W'(height_q);

	assign row_len = ROW_W'(width_q) + ROW_W'(hb_q);

	sbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dividend_q),
		.divisor   (div_divisor_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(RESET_WIDTH);
			height_q <= DIM_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
				REG_ACTIVE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Search sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			// Retire the waiting result; a finished search reloads it in ST_DONE
			if (state_q != ST_DONE && out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					div_start_q <= accept && (frame_period_pixels >= PERIOD_W'(PERIOD_TRIM));
					if (accept) begin
						expo_q     <= exposure_pixels;
						too_long_q <= exposure_pixels > frame_period_pixels;
						found_q    <= 1'b0;
						p_q        <= frame_period_pixels - PERIOD_W'(PERIOD_TRIM);
						best_err_q <= frame_period_pixels - PERIOD_W'(PERIOD_TRIM);
						if (frame_period_pixels >= PERIOD_W'(PERIOD_TRIM)) begin
							div_dividend_q <= ceil_dividend;
							div_divisor_q  <= DIVISOR_W'(row_max);
							state_q        <= ST_DIV_LO;
						end else begin
							// Period too short: nothing to search
							state_q <= ST_SAT;
						end
					end
				end

				ST_DIV_LO: begin
					div_start_q <= div_done;
					if (div_done) begin
						rows_q         <= (ceil_rows > rows_floor) ? ceil_rows : rows_floor;
						div_dividend_q <= DIVIDEND_W'(p_q);
						div_divisor_q  <= DIVISOR_W'(row_min);
						state_q        <= ST_DIV_HI;
					end
				end

				ST_DIV_HI: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						rhi_q   <= div_quo[ROWS_W-1:0];
						steps_q <= '0;
						state_q <= ST_CHECK;
					end
				end

				ST_CHECK: begin
					if (rows_q < rhi_q && steps_q < STEP_W'(MAX_SEARCH_STEPS)) begin
						div_start_q    <= 1'b1;
						div_dividend_q <= DIVIDEND_W'(p_q);
						div_divisor_q  <= rows_q;
						state_q        <= ST_DIV_STEP;
					end else begin
						div_start_q <= 1'b0;
						state_q     <= ST_SAT;
					end
				end

				ST_DIV_STEP: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						// Keep the first row count with the smallest error
						if (step_better) begin
							best_err_q  <= PERIOD_W'(step_err);
							best_quo_q  <= step_quo;
							best_rows_q <= rows_q;
							found_q     <= 1'b1;
						end
						rows_q  <= rows_q + 1'b1;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end

				ST_SAT: begin
					div_start_q <= 1'b0;
					// Saturate the chosen blanking to the field ranges
					if (!found_q) begin
						hb_q <= '0;
						vb_q <= '0;
					end else begin
						if (best_quo_q < QUO_W'(width_q)) begin
							hb_q <= '0;
						end else if (hb_diff > QUO_W'(HB_SAT)) begin
							hb_q <= HB_W'(HB_SAT);
						end else begin
							hb_q <= hb_diff[HB_W-1:0];
						end
						vb_q <= (vb_diff > ROWS_W'(VB_SAT)) ? VB_W'(VB_SAT) : vb_diff[VB_W-1:0];
					end
					state_q <= ST_ROW;
				end

				ST_ROW: begin
					// Split the exposure at the new row length
					if (found_q && row_len != '0) begin
						div_start_q    <= 1'b1;
						div_dividend_q <= DIVIDEND_W'(expo_q);
						div_divisor_q  <= DIVISOR_W'(row_len);
						state_q        <= ST_DIV_EXP;
					end else begin
						div_start_q <= 1'b0;
						coarse_q    <= '0;
						fine_q      <= '0;
						state_q     <= ST_DONE;
					end
				end

				ST_DIV_EXP: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						coarse_q <= div_quo[PERIOD_W-1:0];
						fine_q   <= div_rem[FINE_W-1:0];
						state_q  <= ST_DONE;
					end
				end

				ST_DONE: begin
					div_start_q <= 1'b0;
					// Hold until the output register is free
					if (!out_valid_q || out_ready) begin
						hblank_q       <= hb_q;
						vblank_q       <= vb_q;
						fit_error_q    <= found_q ? best_err_q : '0;
						coarse_rows_q  <= coarse_q;
						fine_pixels_q  <= fine_q;
						too_long_out_q <= too_long_q;
						found_out_q    <= found_q;
						out_valid_q    <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end

				default: begin
					div_start_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign hblank            = hblank_q;
	assign vblank            = vblank_q;
	assign fit_error         = fit_error_q;
	assign coarse_rows       = coarse_rows_q;
	assign fine_pixels       = fine_pixels_q;
	assign exposure_too_long = too_long_out_q;
	assign found             = found_out_q;

endmodule

@@ verif/blanking_checker.sv @@
module blanking_checker #(
	parameter int MAX_STEPS = sbs_pkg::DEF_MAX_SEARCH_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbs_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [sbs_pkg::PERIOD_W-1:0]  frame_period_pixels,
	input  logic [sbs_pkg::PERIOD_W-1:0]  exposure_pixels,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [sbs_pkg::HB_W-1:0]      hblank,
	input  logic [sbs_pkg::VB_W-1:0]      vblank,
	input  logic [sbs_pkg::PERIOD_W-1:0]  fit_error,
	input  logic [sbs_pkg::PERIOD_W-1:0]  coarse_rows,
	input  logic [sbs_pkg::FINE_W-1:0]    fine_pixels,
	input  logic                          exposure_too_long,
	input  logic                          found,
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbs_pkg::*;

	typedef struct packed {
		logic [HB_W-1:0]     hblank;
		logic [VB_W-1:0]     vblank;
		logic [PERIOD_W-1:0] fit_error;
		logic [PERIOD_W-1:0] coarse_rows;
		logic [FINE_W-1:0]   fine_pixels;
		logic                exposure_too_long;
		logic                found;
	} blank_result_t;

	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;
	blank_result_t    pending_results[$];
	blank_result_t    want;
	blank_result_t    got;
	int               delta;
	int               mismatches = 0;

	assign fail_count = mismatches;

	// Search the blanking pair for one period, then split the exposure
	function automatic blank_result_t predict_blanking(input logic [DIM_W-1:0] w_cfg,
			input logic [DIM_W-1:0] h_cfg, input logic [PERIOD_W-1:0] period,
			input logic [PERIOD_W-1:0] expo);
		blank_result_t r;
		longint w, hgt, p, dmax, dmin, vlo, vhi, v, rows, hh, e;
		longint best_err, best_v, best_h, hb, vb, row, coarse;
		int     steps;
		bit     hit;
		r = '0;
		w = w_cfg;
		hgt = h_cfg;
		hit = 1'b0;
		best_err = 0;
		best_v = 0;
		best_h = 0;
		if (period >= PERIOD_TRIM) begin
			p = longint'(period) - PERIOD_TRIM;
			dmax = w + HB_MAX;
			dmin = w + HB_MIN;
			vlo = (p + dmax - 1) / dmax - hgt;
			vhi = p / dmin - hgt;
			if (vlo < VB_MIN)
				vlo = VB_MIN;
			best_err = p;
			steps = 0;
			for (v = vlo; v < vhi && steps < MAX_STEPS; v++) begin
				steps++;
				rows = hgt + v;
				hh = (2 * p + rows) / (2 * rows) - w;
				e = p - (w + hh) * rows;
				if (e < 0)
					e = -e;
				// keep only a strictly better fit, so the first one wins ties
				if (e < best_err) begin
					best_err = e;
					best_v = v;
					best_h = hh;
					hit = 1'b1;
				end
			end
		end
		if (hit) begin
			hb = (best_h < 0) ? 0 : ((best_h > HB_SAT) ? HB_SAT : best_h);
			vb = (best_v > VB_SAT) ? VB_SAT : best_v;
			r.hblank = hb[HB_W-1:0];
			r.vblank = vb[VB_W-1:0];
			r.fit_error = best_err[PERIOD_W-1:0];
			row = w + hb;
			if (row != 0) begin
				coarse = longint'(expo) / row;
				r.coarse_rows = coarse[PERIOD_W-1:0];
				r.fine_pixels = FINE_W'(longint'(expo) - coarse * row);
			end
		end
		r.exposure_too_long = (expo > period);
		r.found = hit;
		return r;
	endfunction

	task automatic check_field(input string name, input longint exp_val, input longint act_val);
		if (exp_val != act_val) begin
			$display("%0t blanking_checker: %s mismatch, expected %0d actual %0d",
				$time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// Track configuration, queue predictions, compare result transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_width <= DIM_W'(RESET_WIDTH);
			cur_height <= DIM_W'(RESET_HEIGHT);
			outstanding <= 0;
			pending_results.delete();
		end else begin
			delta = 0;
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_WIDTH)
					cur_width <= cfg_data;
				else if (cfg_index == REG_ACTIVE_HEIGHT)
					cur_height <= cfg_data;
			end
			if (in_valid && in_ready) begin
				pending_results.push_back(predict_blanking(cur_width, cur_height,
					frame_period_pixels, exposure_pixels));
				delta++;
			end
			if (out_valid && out_ready) begin
				got = '{hblank, vblank, fit_error, coarse_rows, fine_pixels,
					exposure_too_long, found};
				if (pending_results.size() == 0) begin
					$display("%0t blanking_checker: unexpected transaction, expected none actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					delta--;
					check_field("hblank", want.hblank, got.hblank);
					check_field("vblank", want.vblank, got.vblank);
					check_field("fit_error", want.fit_error, got.fit_error);
					check_field("coarse_rows", want.coarse_rows, got.coarse_rows);
					check_field("fine_pixels", want.fine_pixels, got.fine_pixels);
					check_field("exposure_too_long", want.exposure_too_long,
						got.exposure_too_long);
					check_field("found", want.found, got.found);
				end
			end
			outstanding <= outstanding + delta;
		end
	end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sbs_pkg::*;

	localparam longint PERIOD_MAX  = (longint'(1) << PERIOD_W) - 1;
	localparam int     CYCLE_LIMIT = 2000000;
	localparam int     STEP_BUDGET = 64;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PERIOD_W-1:0]  frame_period_pixels;
	logic [PERIOD_W-1:0]  exposure_pixels;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [HB_W-1:0]      hblank;
	logic [VB_W-1:0]      vblank;
	logic [PERIOD_W-1:0]  fit_error;
	logic [PERIOD_W-1:0]  coarse_rows;
	logic [FINE_W-1:0]    fine_pixels;
	logic                 exposure_too_long;
	logic                 found;
	int                   fail_count;
	int                   outstanding;

	int     cycle_count = 0;
	int     stall_mode = 0;
	int     stall_left = 0;
	int     burst_left = 0;
	int     heavy_left = 4;
	longint cur_w = RESET_WIDTH;
	longint cur_h = RESET_HEIGHT;

	sensor_blanking_search_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.frame_period_pixels(frame_period_pixels),
		.exposure_pixels   (exposure_pixels),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hblank            (hblank),
		.vblank            (vblank),
		.fit_error         (fit_error),
		.coarse_rows       (coarse_rows),
		.fine_pixels       (fine_pixels),
		.exposure_too_long (exposure_too_long),
		.found             (found)
	);

	blanking_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.frame_period_pixels(frame_period_pixels),
		.exposure_pixels   (exposure_pixels),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hblank            (hblank),
		.vblank            (vblank),
		.fit_error         (fit_error),
		.coarse_rows       (coarse_rows),
		.fine_pixels       (fine_pixels),
		.exposure_too_long (exposure_too_long),
		.found             (found),
		.fail_count        (fail_count),
		.outstanding       (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Receiver stalls: always ready, coin flip, long hold-off, or mostly ready
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(1, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= 1'b0;
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Offer one transaction and hold it until accepted
	task automatic send_item(input longint period, input longint expo);
		frame_period_pixels <= PERIOD_W'(period);
		exposure_pixels <= PERIOD_W'(expo);
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Send, then idle in bursts with random gaps
	task automatic push_item(input longint period, input longint expo);
		int gap;
		send_item(period, expo);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 30);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(0, 8);
		end
	endtask

	// Drop valid and wait until every result is back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Write both dimension registers back to back
	task automatic write_dims(input longint w, input longint h);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_WIDTH;
		cfg_data <= DIM_W'(w);
		@(posedge clk);
		cfg_index <= REG_ACTIVE_HEIGHT;
		cfg_data <= DIM_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	initial begin
		longint cand, expo, rows, p, lo, hi, span;
		int     tries;
		bit     accepted;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ACTIVE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		frame_period_pixels <= '0;
		exposure_pixels <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions: short periods, empty ranges, exact fit, rounding tie
		push_item(0, 0);
		push_item(3, PERIOD_MAX);
		push_item(4, 5);
		push_item(813 * 484 + 3, 1000);
		push_item(813 * 485 + 4, 813 * 485 + 5);
		push_item(1052 * 500 + 4, 123456);
		push_item(1052 * 500 + 250 + 4, PERIOD_MAX);

		// Largest dimensions: capped search, single step, empty range
		drain();
		write_dims(4095, 4095);
		push_item(PERIOD_MAX, PERIOD_MAX);
		push_item(4156 * 4100 + 4, PERIOD_MAX);
		push_item(4156 * 4099 + 4, 4156 * 4099 + 4);
		push_item(4, 0);

		// Smallest legal dimensions
		drain();
		write_dims(1, 1);
		push_item(PERIOD_MAX, 0);
		push_item(62 * 6 + 4, 61);

		// Zero dimensions: vertical blanking saturates at the top period
		drain();
		write_dims(0, 0);
		push_item(PERIOD_MAX, PERIOD_MAX);
		push_item(305 + 4, 77);
		push_item(61 * 4 + 4, 300);

		// Random phases, mostly short searches near a real blanking pair
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_dims(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4095),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 48));
			for (int n = 0; n < 20; n++) begin
				tries = 0;
				accepted = 1'b0;
				cand = 0;
				while (!accepted) begin
					if (tries >= 200) begin
						cand = $urandom_range(0, 7);
						accepted = 1'b1;
					end else begin
						tries++;
						if ($urandom_range(0, 9) < 6) begin
							rows = cur_h + $urandom_range(0, 48);
							cand = (cur_w + $urandom_range(40, 1100)) * rows
								+ $urandom_range(0, rows) - rows / 2 + PERIOD_TRIM;
						end else begin
							cand = $urandom & ((longint'(1) << $urandom_range(1, PERIOD_W)) - 1);
						end
						if (cand < 0)
							cand = 0;
						if (cand > PERIOD_MAX)
							cand = PERIOD_MAX;
						// estimate the search length to keep the run short
						span = 0;
						if (cand >= PERIOD_TRIM) begin
							p = cand - PERIOD_TRIM;
							lo = (p + cur_w + HB_MAX - 1) / (cur_w + HB_MAX) - cur_h;
							hi = p / (cur_w + HB_MIN) - cur_h;
							if (lo < VB_MIN)
								lo = VB_MIN;
							span = hi - lo;
						end
						if (span <= STEP_BUDGET) begin
							accepted = 1'b1;
						end else if (heavy_left > 0 && $urandom_range(0, 29) == 0) begin
							heavy_left--;
							accepted = 1'b1;
						end
					end
				end
				case ($urandom_range(0, 4)) inside
					0, 1: expo = $urandom & PERIOD_MAX;
					2: expo = cand + $urandom_range(0, 2) - 1;
					3: expo = $urandom_range(0, 8191);
					default: expo = $urandom_range(0, 32'(cand));
				endcase
				if (expo < 0)
					expo = 0;
				if (expo > PERIOD_MAX)
					expo = PERIOD_MAX;
				push_item(cand, expo);
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sbs_pkg.sv
rtl/sbs_div.sv
rtl/sensor_blanking_search_core.sv
verif/blanking_checker.sv
verif/tb_top.sv
